// File: rtl/dghh_pkg.sv
// Shared types and constants of the decaying heat histogram.
`timescale 1ns / 1ps
package dghh_pkg;

    typedef enum logic [1:0] {
        OP_MESSAGE = 2'd0,
        OP_TICK    = 2'd1,
        OP_CLEAR   = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        GEO_GREAT_CIRCLE = 2'd0,
        GEO_ARC          = 2'd1,
        GEO_OTHER        = 2'd2,
        GEO_SPARE        = 2'd3
    } geometry_t;

    localparam logic [1:0] CFG_SHOW_ENABLED = 2'd0;
    localparam logic [1:0] CFG_MAX_REPORTED = 2'd1;

    localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
    localparam logic [31:0] HEAT_MAX  = 32'hFFFF_FFFF;
    localparam logic [16:0] FACTOR_ONE = 17'h1_0000;
    localparam logic [5:0]  CAND_MULT = 6'd50;
    localparam int          LON_OFFSET_Q = 180 * 65536;
    localparam int          LAT_OFFSET_Q = 90 * 65536;
    localparam int          LON_SPAN = 360;
    localparam int          LAT_SPAN = 180;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MSG_BIN,
        ST_MSG_WR_A,
        ST_MSG_RD_B,
        ST_MSG_WR_B,
        ST_DECAY,
        ST_RANK_CHK,
        ST_COUNT,
        ST_SPLIT,
        ST_INORDER,
        ST_TOP,
        ST_TOP_END,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

endpackage

// File: rtl/dghh_ram.sv
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
`timescale 1ns / 1ps
module dghh_ram
    import dghh_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/dghh_bin_lane.sv
// One coordinate binning lane: offset, scale, divide by span, clamp.
`timescale 1ns / 1ps
module dghh_bin_lane
    import dghh_pkg::*;
#(
    parameter int N      = 72,
    parameter int POS_W  = 25,
    parameter int OFF_Q  = 11796480,
    parameter int SPAN   = 360,
    parameter int OW     = 7
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [POS_W-1:0] pos,
    output logic                    q_valid,
    output logic [OW-1:0]           q
);

    localparam int NW = $clog2(N + 1);
    localparam int PW = POS_W + NW;
    localparam int YW = PW - 16;
    localparam int S  = YW + 9;
    localparam int MW = YW + 2;
    localparam logic [63:0] RECIP64 = (64'd1 << S) / SPAN;
    localparam logic [MW-1:0] RECIP = RECIP64[MW-1:0];
    localparam logic [NW-1:0] NV = NW'(N);
    localparam logic [YW+9:0] SPANV = (YW + 10)'(SPAN);
    localparam logic [YW-1:0] QMAX = YW'(N - 1);

    logic signed [POS_W:0] x;
    logic                  v1_reg, v2_reg;
    logic                  neg1_reg, neg2_reg;
    logic [PW-1:0]         prod_reg;
    logic [YW-1:0]         y_reg;
    logic [YW-1:0]         qe_reg;
    logic [YW+MW-1:0]      qe_full;
    logic [YW+9:0]         r;
    logic [YW-1:0]         qc;

    assign x = $signed({pos[POS_W-1], pos}) + (POS_W + 1)'(OFF_Q);
    assign qe_full = (YW + MW)'(prod_reg[PW-1:16]) * (YW + MW)'(RECIP);
    assign r = (YW + 10)'(y_reg) - (YW + 10)'(qe_reg) * SPANV;
    assign qc = (r >= SPANV) ? qe_reg + YW'(1) : qe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            q_valid <= 1'b0;
        end
        else
        begin
            v1_reg  <= start;
            v2_reg  <= v1_reg;
            q_valid <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg1_reg <= x[POS_W];
            prod_reg <= PW'(x[POS_W-1:0]) * PW'(NV);
        end
        if (v1_reg)
        begin
            neg2_reg <= neg1_reg;
            y_reg    <= prod_reg[PW-1:16];
            qe_reg   <= YW'(qe_full[YW+MW-1:S]);
        end
        if (v2_reg)
        begin
            if (neg2_reg)
            begin
                q <= '0;
            end
            else if (qc > QMAX)
            begin
                q <= QMAX[OW-1:0];
            end
            else
            begin
                q <= qc[OW-1:0];
            end
        end
    end

endmodule

// File: rtl/dghh_bin.sv
// Position binning: column and row lanes, then the linear cell index.
`timescale 1ns / 1ps
module dghh_bin
    import dghh_pkg::*;
#(
    parameter int LON_COLUMNS = 72,
    parameter int LAT_ROWS    = 36,
    parameter int AW          = 12
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [24:0] lon,
    input  logic signed [23:0] lat,
    output logic               done,
    output logic [AW-1:0]      idx
);

    localparam int CW = $clog2(LON_COLUMNS);
    localparam int RW = $clog2(LAT_ROWS);

    logic          col_valid, row_valid;
    logic [CW-1:0] col;
    logic [RW-1:0] row;

    dghh_bin_lane #(
        .N(LON_COLUMNS), .POS_W(25), .OFF_Q(LON_OFFSET_Q), .SPAN(LON_SPAN), .OW(CW)
    ) u_col (
        .clk(clk), .rst_n(rst_n), .start(start), .pos(lon),
        .q_valid(col_valid), .q(col)
    );

    dghh_bin_lane #(
        .N(LAT_ROWS), .POS_W(24), .OFF_Q(LAT_OFFSET_Q), .SPAN(LAT_SPAN), .OW(RW)
    ) u_row (
        .clk(clk), .rst_n(rst_n), .start(start), .pos(lat),
        .q_valid(row_valid), .q(row)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= col_valid & row_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_valid)
        begin
            idx <= AW'(AW'(row) * AW'(LON_COLUMNS) + AW'(col));
        end
    end

endmodule

// File: rtl/decaying_geo_heat_histogram.sv
// Top level of the decaying latitude/longitude heat histogram.
// Usage:
//   Requests enter on item_valid/item_stall; one request is taken when valid is
//   high and stall is low. Stall stays high while a request is being worked on.
//   Message request: with enough_points and a great-circle or arc geometry, two
//   bins are computed and both cells get +1.0 by read-modify-write in turn.
//   Tick request: one decay pass over all cells. With display enabled, a nonzero
//   report limit and a peak of at least 1.0, a count pass follows, then either
//   one in-order pass or, if more candidates than the report limit exist, one
//   max-search pass per reported cell. Each report entry is then read from the
//   rank RAM, loaded into the output register and held until it is taken.
//   Clear request: one write sweep over all cells.
//   Results leave on result_valid/result_stall from an output register that holds
//   while the receiver stalls; last marks the final entry of a report.
//   Configuration writes on cfg_valid/cfg_ready are always taken (ready is 1).
//   After reset the grid RAM is zeroed by a sweep over all cells during which
//   no request is taken.
`timescale 1ns / 1ps
module decaying_geo_heat_histogram
    import dghh_pkg::*;
#(
    parameter int LON_COLUMNS  = 72,
    parameter int LAT_ROWS     = 36,
    parameter int REPORT_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         opcode,
    input  logic [1:0]         geometry_kind,
    input  logic               enough_points,
    input  logic signed [24:0] start_lon,
    input  logic signed [23:0] start_lat,
    input  logic signed [24:0] end_lon,
    input  logic signed [23:0] end_lat,
    input  logic [16:0]        decay_factor,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [5:0]         cell_row,
    output logic [6:0]         cell_column,
    output logic [31:0]        heat,
    output logic [31:0]        peak_heat,
    output logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data
);

    localparam int CELLS = LON_COLUMNS * LAT_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(LON_COLUMNS);
    localparam int RW    = $clog2(LAT_ROWS);
    localparam int CNTW  = $clog2(CELLS + 1);
    localparam int KW    = (REPORT_DEPTH > 1) ? $clog2(REPORT_DEPTH) : 1;
    localparam int EW    = RW + CW + 32;
    localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(LON_COLUMNS - 1);
    localparam logic [6:0]    DEPTH7   = 7'(REPORT_DEPTH);

    // Row centre beyond 85 degrees of latitude.
    function automatic logic polar_row(input logic [RW-1:0] row);
        int d;
        d = (2 * int'(row) + 1) * 180 - 180 * LAT_ROWS;
        return (d > 170 * LAT_ROWS) || (-d > 170 * LAT_ROWS);
    endfunction

    state_t          state_reg, state_next;
    logic            show_reg;
    logic [6:0]      maxrep_reg;
    logic [16:0]     factor_reg, factor_next;
    logic [31:0]     peak_reg, peak_next;

    // grid walk
    logic [AW-1:0]   walk_idx_reg, walk_idx_next;
    logic [RW-1:0]   walk_row_reg, walk_row_next;
    logic [CW-1:0]   walk_col_reg, walk_col_next;
    logic            issue_done_reg, issue_done_next;
    logic            p1_valid_reg, p1_valid_next;
    logic [AW-1:0]   p1_idx_reg;
    logic [RW-1:0]   p1_row_reg;
    logic [CW-1:0]   p1_col_reg;
    logic            p2_valid_reg, p2_valid_next;
    logic [AW-1:0]   p2_idx_reg;
    logic [31:0]     p2_val_reg, p2_val_next;

    // ranking
    logic [CNTW-1:0] count_reg, count_next;
    logic [6:0]      wp_reg, wp_next;
    logic [6:0]      sel_k_reg, sel_k_next;
    logic [6:0]      ek_reg, ek_next;
    logic            best_valid_reg, best_valid_next;
    logic [31:0]     best_heat_reg, best_heat_next;
    logic [AW-1:0]   best_idx_reg, best_idx_next;
    logic [RW-1:0]   best_row_reg, best_row_next;
    logic [CW-1:0]   best_col_reg, best_col_next;
    logic            prev_valid_reg, prev_valid_next;
    logic [31:0]     prev_heat_reg, prev_heat_next;
    logic [AW-1:0]   prev_idx_reg, prev_idx_next;

    // output register
    logic            out_valid_reg, out_valid_next;
    logic            out_last_reg, out_last_next;
    logic [RW-1:0]   out_row_reg, out_row_next;
    logic [CW-1:0]   out_col_reg, out_col_next;
    logic [31:0]     out_heat_reg, out_heat_next;

    // memories
    logic            g_we;
    logic [AW-1:0]   g_waddr, g_raddr;
    logic [31:0]     g_wdata, g_rdata;
    logic            r_we;
    logic [KW-1:0]   r_waddr, r_raddr;
    logic [EW-1:0]   r_wdata, r_rdata;

    // binning
    logic            bin_start;
    logic            bin_a_done, bin_b_done;
    logic [AW-1:0]   idx_a, idx_b;

    logic            accept;
    logic [6:0]      limit;
    logic [32:0]     sat_sum;
    logic [31:0]     sat_val;
    logic [48:0]     decay_prod;
    logic [37:0]     heat50;
    logic            cand;
    logic            walk_last;
    logic            eligible;
    logic            better;
    logic            walk_start;
    logic [RW+5:0]   row_ext;
    logic [CW+6:0]   col_ext;

    assign accept     = item_valid & ~item_stall;
    assign item_stall = (state_reg != ST_IDLE);
    assign cfg_ready  = 1'b1;
    assign limit      = (maxrep_reg > DEPTH7) ? DEPTH7 : maxrep_reg;

    assign bin_start = accept && (opcode == OP_MESSAGE) && enough_points &&
                       ((geometry_kind == GEO_GREAT_CIRCLE) || (geometry_kind == GEO_ARC));

    assign sat_sum    = {1'b0, g_rdata} + {1'b0, ONE_Q16};
    assign sat_val    = sat_sum[32] ? HEAT_MAX : sat_sum[31:0];
    assign decay_prod = 49'(g_rdata) * 49'(factor_reg);
    assign heat50     = 38'(g_rdata) * 38'(CAND_MULT);
    assign cand       = heat50 > 38'(peak_reg);
    assign walk_last  = p1_valid_reg && (p1_idx_reg == LAST_IDX);
    assign eligible   = !prev_valid_reg || (g_rdata < prev_heat_reg) ||
                        ((g_rdata == prev_heat_reg) && (p1_idx_reg > prev_idx_reg));
    assign better     = !best_valid_reg || (g_rdata > best_heat_reg);

    assign row_ext      = {6'b0, out_row_reg};
    assign col_ext      = {7'b0, out_col_reg};
    assign cell_row     = row_ext[5:0];
    assign cell_column  = col_ext[6:0];
    assign heat         = out_heat_reg;
    assign peak_heat    = peak_reg;
    assign last         = out_last_reg;
    assign result_valid = out_valid_reg;

    dghh_bin #(.LON_COLUMNS(LON_COLUMNS), .LAT_ROWS(LAT_ROWS), .AW(AW)) u_bin_a (
        .clk(clk), .rst_n(rst_n), .start(bin_start), .lon(start_lon), .lat(start_lat),
        .done(bin_a_done), .idx(idx_a)
    );

    dghh_bin #(.LON_COLUMNS(LON_COLUMNS), .LAT_ROWS(LAT_ROWS), .AW(AW)) u_bin_b (
        .clk(clk), .rst_n(rst_n), .start(bin_start), .lon(end_lon), .lat(end_lat),
        .done(bin_b_done), .idx(idx_b)
    );

    dghh_ram #(.DEPTH(CELLS), .AW(AW), .DW(32)) u_grid (
        .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
        .raddr(g_raddr), .rdata(g_rdata)
    );

    dghh_ram #(.DEPTH(REPORT_DEPTH), .AW(KW), .DW(EW)) u_rank (
        .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
        .raddr(r_raddr), .rdata(r_rdata)
    );

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            show_reg   <= 1'b0;
            maxrep_reg <= 7'd64;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_SHOW_ENABLED)
            begin
                show_reg <= cfg_data[0];
            end
            else if (cfg_index == CFG_MAX_REPORTED)
            begin
                maxrep_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            walk_idx_reg   <= '0;
            walk_row_reg   <= '0;
            walk_col_reg   <= '0;
            issue_done_reg <= 1'b0;
            p1_valid_reg   <= 1'b0;
            p2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
            best_valid_reg <= 1'b0;
            prev_valid_reg <= 1'b0;
            count_reg      <= '0;
            wp_reg         <= '0;
            sel_k_reg      <= '0;
            ek_reg         <= '0;
            peak_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            walk_idx_reg   <= walk_idx_next;
            walk_row_reg   <= walk_row_next;
            walk_col_reg   <= walk_col_next;
            issue_done_reg <= issue_done_next;
            p1_valid_reg   <= p1_valid_next;
            p2_valid_reg   <= p2_valid_next;
            out_valid_reg  <= out_valid_next;
            out_last_reg   <= out_last_next;
            best_valid_reg <= best_valid_next;
            prev_valid_reg <= prev_valid_next;
            count_reg      <= count_next;
            wp_reg         <= wp_next;
            sel_k_reg      <= sel_k_next;
            ek_reg         <= ek_next;
            peak_reg       <= peak_next;
        end
    end

    always_ff @(posedge clk)
    begin
        factor_reg    <= factor_next;
        p1_idx_reg    <= walk_idx_reg;
        p1_row_reg    <= walk_row_reg;
        p1_col_reg    <= walk_col_reg;
        p2_idx_reg    <= p1_idx_reg;
        p2_val_reg    <= p2_val_next;
        best_heat_reg <= best_heat_next;
        best_idx_reg  <= best_idx_next;
        best_row_reg  <= best_row_next;
        best_col_reg  <= best_col_next;
        prev_heat_reg <= prev_heat_next;
        prev_idx_reg  <= prev_idx_next;
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_heat_reg  <= out_heat_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        factor_next     = factor_reg;
        peak_next       = peak_reg;
        walk_start      = 1'b0;
        walk_idx_next   = walk_idx_reg;
        walk_row_next   = walk_row_reg;
        walk_col_next   = walk_col_reg;
        issue_done_next = issue_done_reg;
        p1_valid_next   = 1'b0;
        p2_valid_next   = 1'b0;
        p2_val_next     = decay_prod[47:16];
        count_next      = count_reg;
        wp_next         = wp_reg;
        sel_k_next      = sel_k_reg;
        ek_next         = ek_reg;
        best_valid_next = best_valid_reg;
        best_heat_next  = best_heat_reg;
        best_idx_next   = best_idx_reg;
        best_row_next   = best_row_reg;
        best_col_next   = best_col_reg;
        prev_valid_next = prev_valid_reg;
        prev_heat_next  = prev_heat_reg;
        prev_idx_next   = prev_idx_reg;
        out_valid_next  = out_valid_reg;
        out_last_next   = out_last_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_heat_next   = out_heat_reg;
        g_we    = 1'b0;
        g_waddr = walk_idx_reg;
        g_wdata = '0;
        g_raddr = walk_idx_reg;
        r_we    = 1'b0;
        r_waddr = wp_reg[KW-1:0];
        r_wdata = {p1_row_reg, p1_col_reg, g_rdata};
        r_raddr = ek_reg[KW-1:0];

        // read issue for the walking states
        if ((state_reg == ST_DECAY) || (state_reg == ST_COUNT) ||
            (state_reg == ST_INORDER) || (state_reg == ST_TOP))
        begin
            if (!issue_done_reg)
            begin
                p1_valid_next = 1'b1;
                walk_idx_next = walk_idx_reg + AW'(1);
                if (walk_col_reg == LAST_COL)
                begin
                    walk_col_next = '0;
                    walk_row_next = walk_row_reg + RW'(1);
                end
                else
                begin
                    walk_col_next = walk_col_reg + CW'(1);
                end
                if (walk_idx_reg == LAST_IDX)
                begin
                    issue_done_next = 1'b1;
                end
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                g_we          = 1'b1;
                walk_idx_next = walk_idx_reg + AW'(1);
                if (walk_idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        OP_MESSAGE:
                        begin
                            if (bin_start)
                            begin
                                state_next = ST_MSG_BIN;
                            end
                        end
                        OP_TICK:
                        begin
                            factor_next = (decay_factor > FACTOR_ONE) ? FACTOR_ONE : decay_factor;
                            peak_next   = '0;
                            walk_start  = 1'b1;
                            state_next  = ST_DECAY;
                        end
                        OP_CLEAR:
                        begin
                            walk_start = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_MSG_BIN:
            begin
                g_raddr = idx_a;
                if (bin_a_done && bin_b_done)
                begin
                    state_next = ST_MSG_WR_A;
                end
            end
            ST_MSG_WR_A:
            begin
                g_we       = 1'b1;
                g_waddr    = idx_a;
                g_wdata    = sat_val;
                state_next = ST_MSG_RD_B;
            end
            ST_MSG_RD_B:
            begin
                g_raddr    = idx_b;
                state_next = ST_MSG_WR_B;
            end
            ST_MSG_WR_B:
            begin
                g_we       = 1'b1;
                g_waddr    = idx_b;
                g_wdata    = sat_val;
                state_next = ST_IDLE;
            end
            ST_DECAY:
            begin
                p2_valid_next = p1_valid_reg;
                if (p2_valid_reg)
                begin
                    g_we    = 1'b1;
                    g_waddr = p2_idx_reg;
                    g_wdata = p2_val_reg;
                    if (p2_val_reg > peak_reg)
                    begin
                        peak_next = p2_val_reg;
                    end
                    if (p2_idx_reg == LAST_IDX)
                    begin
                        p2_valid_next = 1'b0;
                        state_next    = ST_RANK_CHK;
                    end
                end
            end
            ST_RANK_CHK:
            begin
                if (show_reg && (peak_reg >= ONE_Q16) && (limit != 7'd0))
                begin
                    count_next = '0;
                    walk_start = 1'b1;
                    state_next = ST_COUNT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COUNT:
            begin
                if (p1_valid_reg && cand)
                begin
                    count_next = count_reg + CNTW'(1);
                end
                if (walk_last)
                begin
                    state_next = ST_SPLIT;
                end
            end
            ST_SPLIT:
            begin
                wp_next         = '0;
                sel_k_next      = '0;
                best_valid_next = 1'b0;
                prev_valid_next = 1'b0;
                walk_start      = 1'b1;
                if (32'(count_reg) <= 32'(limit))
                begin
                    state_next = ST_INORDER;
                end
                else
                begin
                    state_next = ST_TOP;
                end
            end
            ST_INORDER:
            begin
                if (p1_valid_reg && cand && !polar_row(p1_row_reg))
                begin
                    r_we    = 1'b1;
                    wp_next = wp_reg + 7'd1;
                end
                if (walk_last)
                begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_TOP:
            begin
                if (p1_valid_reg && eligible && better)
                begin
                    best_valid_next = 1'b1;
                    best_heat_next  = g_rdata;
                    best_idx_next   = p1_idx_reg;
                    best_row_next   = p1_row_reg;
                    best_col_next   = p1_col_reg;
                end
                if (walk_last)
                begin
                    state_next = ST_TOP_END;
                end
            end
            ST_TOP_END:
            begin
                r_wdata = {best_row_reg, best_col_reg, best_heat_reg};
                if (!polar_row(best_row_reg))
                begin
                    r_we    = 1'b1;
                    wp_next = wp_reg + 7'd1;
                end
                prev_valid_next = 1'b1;
                prev_heat_next  = best_heat_reg;
                prev_idx_next   = best_idx_reg;
                best_valid_next = 1'b0;
                sel_k_next      = sel_k_reg + 7'd1;
                if (sel_k_reg + 7'd1 == limit)
                begin
                    state_next = ST_EMIT_RD;
                end
                else
                begin
                    walk_start = 1'b1;
                    state_next = ST_TOP;
                end
            end
            ST_EMIT_RD:
            begin
                if (wp_reg == 7'd0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD:
            begin
                out_valid_next = 1'b1;
                out_last_next  = (ek_reg + 7'd1 == wp_reg);
                out_row_next   = r_rdata[EW-1:CW+32];
                out_col_next   = r_rdata[CW+31:32];
                out_heat_next  = r_rdata[31:0];
                state_next     = ST_EMIT_WAIT;
            end
            ST_EMIT_WAIT:
            begin
                if (out_valid_reg && !result_stall)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        ek_next    = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ek_next    = ek_reg + 7'd1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (walk_start)
        begin
            walk_idx_next   = '0;
            walk_row_next   = '0;
            walk_col_next   = '0;
            issue_done_next = 1'b0;
        end
    end

endmodule
